// ----- hw/rtl/clws_pkg.sv -----
// Shared types, command codes and helper functions for the character LCD write sequencer.
// Used by clws_write_seq and char_lcd_write_sequencer_top; depends on nothing else.
package clws_pkg;

  typedef enum logic [2:0] {
    CMD_INSTR = 3'd0,
    CMD_CHAR  = 3'd1,
    CMD_BYTE  = 3'd2,
    CMD_WORD  = 3'd3,
    CMD_MOVE  = 3'd4,
    CMD_CLEAR = 3'd5,
    CMD_HOME  = 3'd6,
    CMD_INIT  = 3'd7
  } cmd_t;

  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned MAX_WRITES = 5;

  localparam logic [13:0] W_10000 = 14'd10000;
  localparam logic [13:0] W_1000  = 14'd1000;
  localparam logic [13:0] W_100   = 14'd100;
  localparam logic [13:0] W_10    = 14'd10;

  localparam logic [7:0]  ASCII_ZERO   = 8'd48;
  localparam logic [7:0]  DISP_CLEAR   = 8'h01;
  localparam logic [7:0]  RETURN_HOME  = 8'h02;
  localparam logic [7:0]  LCD_FUNC_SET = 8'h38;
  localparam logic [7:0]  LCD_DISP_ON  = 8'h0c;
  localparam logic [7:0]  LCD_ENTRY    = 8'h06;

  localparam logic [1:0]  EN_FAST   = 2'd1;
  localparam logic [1:0]  EN_SLOW   = 2'd2;
  localparam logic [10:0] WAIT_FAST = 11'd40;
  localparam logic [10:0] WAIT_SLOW = 11'd2000;

  // One bus write before its timing fields are expanded.
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       slow;
  } write_t;

  // All writes of one command plus how many of them are used.
  typedef struct packed {
    logic [2:0]   cnt;
    write_t [4:0] w;
  } burst_t;

  // One pipeline stage of the digit extraction.
  typedef struct packed {
    cmd_t         cmd;
    logic [7:0]   lowb;
    logic [5:0]   col;
    logic         row;
    logic [15:0]  rem;
    logic [4:0][3:0] dig;
  } stage_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [15:0] rem;
  } digit_t;

  // One decimal digit by parallel compares against the multiples of a constant weight.
  function automatic digit_t digit_step(logic [15:0] rem, logic [13:0] weight);
    digit_t      r;
    logic [17:0] prod;
    r.digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      prod = 18'(k) * {4'b0, weight};
      if ({2'b0, rem} >= prod) begin
        r.digit = 4'(k);
      end
    end
    r.rem = 16'({2'b0, rem} - 18'({14'b0, r.digit} * {4'b0, weight}));
    return r;
  endfunction

  function automatic write_t mk_write(logic rs, logic [7:0] data, logic slow);
    write_t w;
    w.rs   = rs;
    w.data = data;
    w.slow = slow;
    return w;
  endfunction

  function automatic logic [7:0] ascii_digit(logic [3:0] d);
    return ASCII_ZERO + {4'b0, d};
  endfunction

  // Turns a fully decoded stage into its list of bus writes.
  function automatic burst_t build_burst(stage_t s);
    burst_t b;
    b.cnt = 3'd1;
    b.w   = '0;
    unique case (s.cmd)
      CMD_INSTR: b.w[0] = mk_write(1'b0, s.lowb, 1'b0);
      CMD_CHAR:  b.w[0] = mk_write(1'b1, s.lowb, 1'b0);
      CMD_BYTE: begin
        b.cnt = 3'd3;
        for (int i = 0; i < 3; i++) begin
          b.w[i] = mk_write(1'b1, ascii_digit(s.dig[2 - i]), 1'b0);
        end
      end
      CMD_WORD: begin
        b.cnt = 3'd5;
        for (int i = 0; i < 5; i++) begin
          b.w[i] = mk_write(1'b1, ascii_digit(s.dig[4 - i]), 1'b0);
        end
      end
      CMD_MOVE:  b.w[0] = mk_write(1'b0, {1'b1, s.row, s.col}, 1'b0);
      CMD_CLEAR: b.w[0] = mk_write(1'b0, DISP_CLEAR, 1'b1);
      CMD_HOME:  b.w[0] = mk_write(1'b0, RETURN_HOME, 1'b1);
      CMD_INIT: begin
        b.cnt  = 3'd4;
        b.w[0] = mk_write(1'b0, LCD_FUNC_SET, 1'b0);
        b.w[1] = mk_write(1'b0, LCD_DISP_ON, 1'b0);
        b.w[2] = mk_write(1'b0, LCD_ENTRY, 1'b0);
        b.w[3] = mk_write(1'b0, DISP_CLEAR, 1'b1);
      end
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/clws_write_seq.sv -----
// Write sequencer: holds one command's writes and issues them one per cycle, while the
// master stream takes them, into an output register that feeds it. Depends on clws_pkg.
module clws_write_seq
  import clws_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  burst_t       in_burst,
  output logic         in_ready,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata,   // bus_byte[7:0], enable_us[9:8], wait_us[20:10], zeros
  output logic         m_tuser,   // register_select
  output logic         m_tlast
);

  burst_t     burst;
  logic       busy;
  logic [2:0] idx;
  logic       emit;
  logic       is_last;
  write_t     cur;

  logic       out_rs;
  logic [7:0] out_data;
  logic       out_slow;
  logic       out_last;

  assign cur      = burst.w[idx];
  assign is_last  = (idx == (burst.cnt - 3'd1));
  assign emit     = busy && (!m_tvalid || m_tready);
  assign in_ready = !busy || (emit && is_last);

  // A new command is taken only when idle or on the last write of the current one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (emit) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      burst <= in_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rs   <= cur.rs;
      out_data <= cur.data;
      out_slow <= cur.slow;
      out_last <= is_last;
    end
  end

  assign m_tdata = {3'b0, out_slow ? WAIT_SLOW : WAIT_FAST,
                    out_slow ? EN_SLOW : EN_FAST, out_data};
  assign m_tuser = out_rs;
  assign m_tlast = out_last;

endmodule

// ----- hw/rtl/char_lcd_write_sequencer_top.sv -----
// Top level of the character LCD write sequencer: input register, four digit stages and
// the write sequencer. Depends on clws_pkg and clws_write_seq.
//
// Usage: each transfer on the slave stream is one command (tuser) with its value, column
// and row (tdata). The block answers with the bus writes the command causes on the master
// stream, one write per transfer: register select in tuser, the data byte, the enable pulse
// length and the post-write wait in tdata, and tlast on the final write of the command.
// The first write of a command reaches the master side through the input register, four
// digit stages and the sequencer's output register.
// Throughput: the master side carries one write per cycle while the receiver keeps tready
// high; a command has one write for instruction, character, move, clear and home, three
// for a byte in decimal, four for init, five for a word in decimal. The write sequencer
// sets that rate; the pipeline ahead of it accepts a new command every cycle while it
// has room.
// Reset clears every valid bit, so the pipeline and the output come up empty.
// When the receiver stalls, the output register holds its write, the sequencer and then
// the pipeline stages fill up behind it, and tready on the slave side drops once the input
// register is full. Nothing is lost or repeated.
module char_lcd_write_sequencer_top
  import clws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // value[15:0], column[21:16], row[22], zero[23]
  input  logic [2:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // bus_byte[7:0], enable_us[9:8], wait_us[20:10], zeros
  output logic        m_tuser,   // register_select
  output logic        m_tlast
);

  // Stage 0 is the input register; stages 1 to 4 extract the ten-thousands, thousands,
  // hundreds and then tens plus units digits. A byte command enters with only its low
  // byte as the number, so its upper digits come out zero.
  stage_t     stg [NUM_DIGITS];
  stage_t     stg_next [NUM_DIGITS];
  logic [4:0] vld;
  logic [4:0] rdy;
  logic       seq_ready;
  burst_t     burst;
  digit_t     d1;
  digit_t     d2;
  digit_t     d3;
  digit_t     d4;

  // A stage can take new contents when it is empty or its contents move on.
  always_comb begin
    rdy[4] = !vld[4] || seq_ready;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i + 1];
    end
  end

  assign s_tready = rdy[0];

  always_comb begin
    stg_next[0].cmd  = cmd_t'(s_tuser);
    stg_next[0].lowb = s_tdata[7:0];
    stg_next[0].col  = s_tdata[21:16];
    stg_next[0].row  = s_tdata[22];
    stg_next[0].rem  = (cmd_t'(s_tuser) == CMD_BYTE) ? {8'b0, s_tdata[7:0]} : s_tdata[15:0];
    stg_next[0].dig  = '0;

    d1 = digit_step(stg[0].rem, W_10000);
    stg_next[1]        = stg[0];
    stg_next[1].dig[4] = d1.digit;
    stg_next[1].rem    = d1.rem;

    d2 = digit_step(stg[1].rem, W_1000);
    stg_next[2]        = stg[1];
    stg_next[2].dig[3] = d2.digit;
    stg_next[2].rem    = d2.rem;

    d3 = digit_step(stg[2].rem, W_100);
    stg_next[3]        = stg[2];
    stg_next[3].dig[2] = d3.digit;
    stg_next[3].rem    = d3.rem;

    // The remainder after the tens is below ten and is the units digit itself.
    d4 = digit_step(stg[3].rem, W_10);
    stg_next[4]        = stg[3];
    stg_next[4].dig[1] = d4.digit;
    stg_next[4].dig[0] = d4.rem[3:0];
    stg_next[4].rem    = d4.rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NUM_DIGITS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (rdy[i]) begin
        stg[i] <= stg_next[i];
      end
    end
  end

  assign burst = build_burst(stg[4]);

  clws_write_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[4]),
    .in_burst (burst),
    .in_ready (seq_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // A command waiting at the end of the pipeline keeps its contents until the sequencer
  // takes it.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !seq_ready) |=> (vld[4] && $stable(stg[4])))
    else $error("last pipeline stage changed while stalled");

  // A byte command has no ten-thousands or thousands digit.
  a_byte_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && stg[4].cmd == CMD_BYTE) |-> (stg[4].dig[4] == 4'd0 && stg[4].dig[3] == 4'd0))
    else $error("byte command produced an upper digit");

  // Every extracted digit is a decimal digit.
  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (stg[4].dig[4] <= 4'd9 && stg[4].dig[3] <= 4'd9 && stg[4].dig[2] <= 4'd9 &&
                stg[4].dig[1] <= 4'd9 && stg[4].dig[0] <= 4'd9))
    else $error("digit out of range");

  // Slow timing always pairs the long wait with the long enable pulse.
  a_timing_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[20:10] == WAIT_SLOW) == (m_tdata[9:8] == EN_SLOW)))
    else $error("enable and wait timing disagree");

endmodule

// ----- test/char_lcd_write_sequencer_top_test.sv -----
// Self-checking testbench for char_lcd_write_sequencer_top: drives command transfers with
// random gaps and checks every LCD bus write against a predictor kept in a scoreboard class.
// Depends on clws_pkg and the RTL of the sequencer only.
module char_lcd_write_sequencer_top_test;
  import clws_pkg::*;

  // Timing and bus constants of the HD44780-style protocol as seen on the output.
  localparam logic [7:0]  DIGIT_BASE     = 8'd48;
  localparam logic [7:0]  INSTR_CLEAR    = 8'h01;
  localparam logic [7:0]  INSTR_HOME     = 8'h02;
  localparam logic [7:0]  INSTR_FUNCSET  = 8'h38;
  localparam logic [7:0]  INSTR_DISPLAY  = 8'h0c;
  localparam logic [7:0]  INSTR_ENTRY    = 8'h06;
  localparam logic [7:0]  DDRAM_BASE     = 8'd128;
  localparam logic [1:0]  PULSE_SHORT    = 2'd1;
  localparam logic [1:0]  PULSE_LONG     = 2'd2;
  localparam logic [10:0] SETTLE_SHORT   = 11'd40;
  localparam logic [10:0] SETTLE_LONG    = 11'd2000;
  localparam logic        RS_INSTRUCTION = 1'b0;
  localparam logic        RS_DATA        = 1'b1;

  localparam int RANDOM_COMMANDS = 300;
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int HOLDOFF_AT      = 60;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 200000;

  // The scoreboard holds the predictor and the queue of bus writes still to come.
  class lcd_write_scoreboard;
    typedef struct {
      logic        rs;
      logic [7:0]  bus_byte;
      logic [1:0]  enable_us;
      logic [10:0] wait_us;
      logic        last;
    } lcd_write_t;

    lcd_write_t pending_writes[$];
    int         mismatches;
    int         writes_checked;
    int         commands_by_kind[8];

    function new();
      mismatches     = 0;
      writes_checked = 0;
      foreach (commands_by_kind[i]) commands_by_kind[i] = 0;
    endfunction

    function void push_write(logic rs, logic [7:0] bus_byte, logic slow);
      lcd_write_t w;
      w.rs        = rs;
      w.bus_byte  = bus_byte;
      w.enable_us = slow ? PULSE_LONG : PULSE_SHORT;
      w.wait_us   = slow ? SETTLE_LONG : SETTLE_SHORT;
      w.last      = 1'b0;
      pending_writes.push_back(w);
    endfunction

    // Emits the ASCII digits of num, most significant first, one per weight.
    function void push_digits(int unsigned num, int unsigned ndigits);
      int unsigned weights[5] = '{10000, 1000, 100, 10, 1};
      int unsigned d;
      for (int i = 5 - ndigits; i < 5; i++) begin
        d   = num / weights[i];
        num = num - d * weights[i];
        push_write(RS_DATA, DIGIT_BASE + 8'(d), 1'b0);
      end
    endfunction

    function void note_command(cmd_t cmd, logic [15:0] value, logic [5:0] column,
                               logic row);
      commands_by_kind[cmd]++;
      case (cmd)
        CMD_INSTR: push_write(RS_INSTRUCTION, value[7:0], 1'b0);
        CMD_CHAR:  push_write(RS_DATA, value[7:0], 1'b0);
        CMD_BYTE:  push_digits(value[7:0], 3);
        CMD_WORD:  push_digits(value, 5);
        CMD_MOVE:  push_write(RS_INSTRUCTION, DDRAM_BASE + (row ? 8'd64 : 8'd0) + column,
                              1'b0);
        CMD_CLEAR: push_write(RS_INSTRUCTION, INSTR_CLEAR, 1'b1);
        CMD_HOME:  push_write(RS_INSTRUCTION, INSTR_HOME, 1'b1);
        default: begin
          push_write(RS_INSTRUCTION, INSTR_FUNCSET, 1'b0);
          push_write(RS_INSTRUCTION, INSTR_DISPLAY, 1'b0);
          push_write(RS_INSTRUCTION, INSTR_ENTRY, 1'b0);
          push_write(RS_INSTRUCTION, INSTR_CLEAR, 1'b1);
        end
      endcase
      pending_writes[pending_writes.size() - 1].last = 1'b1;
    endfunction

    function void check_write(logic rs, logic [23:0] tdata, logic last);
      lcd_write_t w;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        $error("unexpected bus write: rs %0d tdata %h last %0d", rs, tdata, last);
        mismatches++;
        return;
      end
      w = pending_writes.pop_front();
      if (rs !== w.rs) begin
        $error("register_select expected %0d actual %0d", w.rs, rs);
        mismatches++;
      end
      if (tdata[7:0] !== w.bus_byte) begin
        $error("bus_byte expected %0d actual %0d", w.bus_byte, tdata[7:0]);
        mismatches++;
      end
      if (tdata[9:8] !== w.enable_us) begin
        $error("enable_us expected %0d actual %0d", w.enable_us, tdata[9:8]);
        mismatches++;
      end
      if (tdata[20:10] !== w.wait_us) begin
        $error("wait_us expected %0d actual %0d", w.wait_us, tdata[20:10]);
        mismatches++;
      end
      if (tdata[23:21] !== 3'b000) begin
        $error("tdata padding expected 0 actual %0d", tdata[23:21]);
        mismatches++;
      end
      if (last !== w.last) begin
        $error("last expected %0d actual %0d", w.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // value[15:0], column[21:16], row[22], zero[23]
  logic [2:0]  s_tuser;   // command
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // bus_byte[7:0], enable_us[9:8], wait_us[20:10], zeros
  logic        m_tuser;   // register_select
  logic        m_tlast;

  lcd_write_scoreboard write_board;
  int  commands_sent;
  int  cycle_count;
  bit  holdoff_done;

  char_lcd_write_sequencer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every run of 40 transfers in three goes without any idling, so back-to-back traffic
  // is covered as well as random gaps.
  function automatic int draw_gap(int index);
    if ((index / 40) % 3 == 1) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Offers one command on the slave stream and returns at the falling edge after the
  // transfer. The caller is always at a falling edge, so tvalid stays high between
  // back-to-back commands and only drops when a gap is drawn.
  task automatic drive_command(cmd_t cmd, logic [15:0] value, logic [5:0] column, logic row);
    int gap;
    gap = draw_gap(commands_sent);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {1'b0, row, column, value};
    do @(posedge clk); while (!s_tready);
    write_board.note_command(cmd, value, column, row);
    commands_sent++;
    @(negedge clk);
  endtask

  // Accepts writes on the master stream forever. Once, after a few dozen writes, the
  // receiver holds tready low for a long stretch so that the pipeline fills up and the
  // slave side has to stall while the sender keeps offering commands.
  task automatic accept_writes();
    int gap;
    forever begin
      gap = draw_gap(write_board.writes_checked);
      if (!holdoff_done && write_board.writes_checked >= HOLDOFF_AT) begin
        gap          = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      write_board.check_write(m_tuser, m_tdata, m_tlast);
      @(negedge clk);
    end
  endtask

  // Picks a value that is an edge case about one time in six, otherwise a random word.
  function automatic logic [15:0] draw_value();
    logic [15:0] edges[8] = '{16'h0000, 16'hffff, 16'h00ff, 16'hff00, 16'd9999,
                              16'd10000, 16'd99, 16'd100};
    if ($urandom_range(0, 5) == 0) return edges[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  task automatic run_directed();
    // Instruction and character writes ignore the upper byte of the value.
    drive_command(CMD_INSTR, 16'h0000, 6'd0, 1'b0);
    drive_command(CMD_INSTR, 16'hffff, 6'd63, 1'b1);
    drive_command(CMD_CHAR, 16'hff00, 6'd21, 1'b1);
    drive_command(CMD_CHAR, 16'h5a41, 6'd42, 1'b0);
    drive_command(CMD_CHAR, 16'h00ff, 6'd0, 1'b0);
    // Byte decimal uses only the low byte: 0, 255, 100 and 9 with junk above.
    drive_command(CMD_BYTE, 16'h0000, 6'd0, 1'b0);
    drive_command(CMD_BYTE, 16'h00ff, 6'd63, 1'b1);
    drive_command(CMD_BYTE, 16'hab64, 6'd5, 1'b0);
    drive_command(CMD_BYTE, 16'hff09, 6'd0, 1'b1);
    // Word decimal at the ends and around the digit boundaries, zeros not blanked.
    drive_command(CMD_WORD, 16'd0, 6'd0, 1'b0);
    drive_command(CMD_WORD, 16'd65535, 6'd63, 1'b1);
    drive_command(CMD_WORD, 16'd10000, 6'd1, 1'b0);
    drive_command(CMD_WORD, 16'd9999, 6'd2, 1'b1);
    drive_command(CMD_WORD, 16'd50505, 6'd3, 1'b0);
    // Cursor moves at the corners of both rows; the value plays no part.
    drive_command(CMD_MOVE, 16'h0000, 6'd0, 1'b0);
    drive_command(CMD_MOVE, 16'hffff, 6'd63, 1'b1);
    drive_command(CMD_MOVE, 16'h1234, 6'd63, 1'b0);
    drive_command(CMD_MOVE, 16'hffff, 6'd0, 1'b1);
    // Clear, home and init with junk in the fields they do not use.
    drive_command(CMD_CLEAR, 16'hffff, 6'd63, 1'b1);
    drive_command(CMD_HOME, 16'hffff, 6'd63, 1'b1);
    drive_command(CMD_CLEAR, 16'h0000, 6'd0, 1'b0);
    drive_command(CMD_INIT, 16'h0000, 6'd0, 1'b0);
    drive_command(CMD_INIT, 16'hffff, 6'd63, 1'b1);
    drive_command(CMD_HOME, 16'h0000, 6'd0, 1'b0);
  endtask

  // Random part: mostly free commands, with screen-writing runs of init, a move and a few
  // characters or numbers mixed in, as a real display driver would send them.
  task automatic run_random();
    int n;
    int run_len;
    n = 0;
    while (n < RANDOM_COMMANDS) begin
      if ($urandom_range(0, 7) == 0) begin
        drive_command(CMD_INIT, draw_value(), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
        drive_command(CMD_MOVE, draw_value(), 6'($urandom_range(0, 63)),
                      1'($urandom_range(0, 1)));
        run_len = $urandom_range(1, 4);
        repeat (run_len) begin
          drive_command(cmd_t'($urandom_range(CMD_CHAR, CMD_WORD)), draw_value(),
                        6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        end
        n += 2 + run_len;
      end else begin
        drive_command(cmd_t'($urandom_range(0, 7)), draw_value(),
                      6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        n++;
      end
    end
  endtask

  // The run cannot hang: past the limit it ends as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("char_lcd_write_sequencer_top regression: fail");
      $finish;
    end
  end

  initial begin
    // All inputs start from known values; reset is held, then released at a falling edge
    // so the first command is offered cleanly.
    write_board   = new();
    commands_sent = 0;
    cycle_count   = 0;
    holdoff_done  = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_INSTR;
    m_tready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    fork
      accept_writes();
    join_none

    run_directed();
    run_random();
    s_tvalid = 1'b0;

    // Wait until every predicted write has arrived, then give the pipeline time to show
    // any write that should not exist.
    while (write_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands (instr %0d, char %0d, byte %0d, word %0d,",
             commands_sent, write_board.commands_by_kind[CMD_INSTR],
             write_board.commands_by_kind[CMD_CHAR], write_board.commands_by_kind[CMD_BYTE],
             write_board.commands_by_kind[CMD_WORD]);
    $display("  move %0d, clear %0d, home %0d, init %0d) and %0d bus writes, %0d mismatches.",
             write_board.commands_by_kind[CMD_MOVE], write_board.commands_by_kind[CMD_CLEAR],
             write_board.commands_by_kind[CMD_HOME], write_board.commands_by_kind[CMD_INIT],
             write_board.writes_checked, write_board.mismatches);
    if (write_board.mismatches == 0) begin
      $display("char_lcd_write_sequencer_top regression: pass");
    end else begin
      $display("char_lcd_write_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/clws_pkg.sv
hw/rtl/clws_write_seq.sv
hw/rtl/char_lcd_write_sequencer_top.sv
test/char_lcd_write_sequencer_top_test.sv
